FILE: rtl/core/lru_k_frame_replacer_macros.svh
// Assertion helpers used by the replacer top level.
`ifndef LRU_K_FRAME_REPLACER_MACROS_SVH
`define LRU_K_FRAME_REPLACER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define LKFR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define LKFR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/lkfr_pkg.sv
`default_nettype none
package lkfr_pkg;

   // Default sizes for the top level.
   localparam int NumFramesDefault  = 64;
   localparam int KMaxDefault       = 8;
   localparam int StampWidthDefault = 48;

   // Register reset values.
   localparam logic [6:0] FramesInUseReset  = 7'd64;
   localparam logic [3:0] HistoryDepthReset = 4'd2;

   // Register indexes.
   localparam logic RegFramesInUse  = 1'b0;
   localparam logic RegHistoryDepth = 1'b1;

   // Request codes.
   localparam logic [1:0] OpAccess  = 2'd0;
   localparam logic [1:0] OpSetMark = 2'd1;
   localparam logic [1:0] OpRemove  = 2'd2;
   localparam logic [1:0] OpEvict   = 2'd3;

   // Result codes.
   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusEmpty   = 2'd1;
   localparam logic [1:0] StatusInvalid = 2'd2;
   localparam logic [1:0] StatusPinned  = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [5:0] frame;
      logic       make_evictable;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] victim_frame;
      logic [6:0] evictable_count;
   } rsp_type;

   // Progress of the victim search.
   typedef struct packed {
      logic found;
      logic done;
   } sel_status_type;

   typedef enum logic [4:0] {
      ST_CLR  = 5'b00001,
      ST_IDLE = 5'b00010,
      ST_EXEC = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/core/lkfr_victim_sel.sv
`default_nettype none
module lkfr_victim_sel #(
   parameter int FRAME_COUNT = lkfr_pkg::NumFramesDefault,
   parameter int K_MAX       = lkfr_pkg::KMaxDefault,
   parameter int STAMP_WIDTH = lkfr_pkg::StampWidthDefault
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       clear,
   input  wire logic [$clog2(K_MAX+1)-1:0]                 k_eff,
   input  wire logic                                       meta_valid,
   input  wire logic [$clog2(FRAME_COUNT)-1:0]             meta_idx,
   input  wire logic [((K_MAX > 1) ? $clog2(K_MAX) : 1)+$clog2(K_MAX+1)+1:0] meta_data,
   output logic      [$clog2(FRAME_COUNT*K_MAX)-1:0]       stamp_addr,
   input  wire logic [STAMP_WIDTH-1:0]                     stamp_data,
   output lkfr_pkg::sel_status_type                        sel,
   output logic      [$clog2(FRAME_COUNT)-1:0]             victim_idx
);

   localparam int IDX_W  = $clog2(FRAME_COUNT);
   localparam int CNT_W  = $clog2(K_MAX+1);
   localparam int HEAD_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam int SA_W   = $clog2(FRAME_COUNT*K_MAX);
   localparam int PW     = CNT_W + 1;

   logic              trk, ev, is_short, key_zero;
   logic [CNT_W-1:0]  cnt, j;
   logic [HEAD_W-1:0] head;
   logic [PW-1:0]     pos;

   logic              s2_valid_ff, s2_valid_in;
   logic [IDX_W-1:0]  s2_idx_ff;
   logic              s2_elig_ff, s2_short_ff, s2_zero_ff;
   logic              found_ff, found_in;
   logic              best_short_ff, best_short_in;
   logic [STAMP_WIDTH-1:0] best_ff, best_in, key;
   logic [IDX_W-1:0]  victim_ff, victim_in;
   logic              take;

   // First stage: pick which kept stamp is this frame's key.
   always_comb begin
      head     = meta_data[HEAD_W-1:0];
      cnt      = meta_data[HEAD_W +: CNT_W];
      ev       = meta_data[HEAD_W+CNT_W];
      trk      = meta_data[HEAD_W+CNT_W+1];
      is_short = cnt < k_eff;
      key_zero = is_short && (cnt == '0);
      j        = is_short ? cnt : k_eff;
      if (PW'(j) > PW'(head)) begin
         pos = PW'(head) + PW'(K_MAX) - PW'(j);
      end else begin
         pos = PW'(head) - PW'(j);
      end
      stamp_addr = SA_W'(meta_idx) * SA_W'(K_MAX) + SA_W'(pos);
   end

   // Second stage: compare the fetched key against the best so far.
   always_comb begin
      key  = s2_zero_ff ? '0 : stamp_data;
      take = s2_valid_ff && s2_elig_ff &&
             (!found_ff || (s2_short_ff && !best_short_ff) ||
              ((s2_short_ff == best_short_ff) && (key < best_ff)));
      found_in      = take ? 1'b1 : found_ff;
      best_short_in = take ? s2_short_ff : best_short_ff;
      best_in       = take ? key : best_ff;
      victim_in     = take ? s2_idx_ff : victim_ff;
      s2_valid_in   = meta_valid;
      if (clear) begin
         found_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         found_ff    <= found_in;
      end
      s2_idx_ff     <= meta_idx;
      s2_elig_ff    <= trk && ev;
      s2_short_ff   <= is_short;
      s2_zero_ff    <= key_zero;
      best_short_ff <= best_short_in;
      best_ff       <= best_in;
      victim_ff     <= victim_in;
   end

   // Done flags the last compare; the result registers after it.
   assign sel.done   = s2_valid_ff && (s2_idx_ff == IDX_W'(FRAME_COUNT-1));
   assign sel.found  = found_ff;
   assign victim_idx = victim_ff;

endmodule
`default_nettype wire

FILE: rtl/core/lru_k_frame_replacer.sv
// Access, mark and remove words run through ST_EXEC and give a registered result; a new
// word is taken only once the block is back in idle.
// Evict scans every frame through the metadata and stamp memories, one frame per
// cycle, then answers from ST_FIN; busy stays high until the one-cycle result
// strobe, which the receiver cannot stall.
// Reset is synchronous; a clearing pass then zeroes the metadata memory.
`default_nettype none
`include "lru_k_frame_replacer_macros.svh"
module lru_k_frame_replacer #(
   parameter int FRAME_COUNT = lkfr_pkg::NumFramesDefault,
   parameter int K_MAX       = lkfr_pkg::KMaxDefault,
   parameter int STAMP_WIDTH = lkfr_pkg::StampWidthDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire lkfr_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output lkfr_pkg::rsp_type      rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int IDX_W  = $clog2(FRAME_COUNT);
   localparam int CNT_W  = $clog2(K_MAX+1);
   localparam int HEAD_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam int META_W = HEAD_W + CNT_W + 2;
   localparam int SA_W   = $clog2(FRAME_COUNT*K_MAX);
   localparam int TOT_W  = $clog2(FRAME_COUNT+1);

   lkfr_pkg::state_type state_ff, state_in;
   lkfr_pkg::req_type   req_ff;
   lkfr_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [6:0]          fiu_ff;
   logic [3:0]          hd_ff;
   logic [TOT_W-1:0]    total_ff, total_in;
   logic [STAMP_WIDTH-1:0] clock_ff, clock_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                issue_ff, issue_in;
   logic                s1_valid_ff;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic                accept, csr_wr, in_range;
   logic [CNT_W-1:0]    k_eff;

   // Memories.
   logic [META_W-1:0]      meta_mem [FRAME_COUNT];
   logic [STAMP_WIDTH-1:0] stamp_mem [FRAME_COUNT*K_MAX];
   logic [META_W-1:0]      meta_rd, meta_wdata;
   logic [IDX_W-1:0]       meta_raddr, meta_waddr;
   logic                   meta_we, stamp_we;
   logic [STAMP_WIDTH-1:0] stamp_rd;
   logic [SA_W-1:0]        stamp_raddr, stamp_waddr;

   lkfr_pkg::sel_status_type sel;
   logic [IDX_W-1:0]         victim_idx;

   // Fields of the current frame's metadata word.
   logic              m_trk, m_ev;
   logic [CNT_W-1:0]  m_cnt;
   logic [HEAD_W-1:0] m_head;

   assign accept     = start && !busy;
   assign busy       = (state_ff != lkfr_pkg::ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == lkfr_pkg::RegHistoryDepth) ?
                       {28'd0, hd_ff} : {25'd0, fiu_ff};

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff <= lkfr_pkg::FramesInUseReset;
         hd_ff  <= lkfr_pkg::HistoryDepthReset;
      end else if (csr_wr) begin
         if (csr_paddr[2] == lkfr_pkg::RegHistoryDepth) begin
            hd_ff <= csr_pwdata[3:0];
         end else begin
            fiu_ff <= csr_pwdata[6:0];
         end
      end
   end

   // Effective K, clamped into one to K_MAX.
   always_comb begin
      if (hd_ff == 4'd0) begin
         k_eff = CNT_W'(1);
      end else if (32'(hd_ff) > K_MAX) begin
         k_eff = CNT_W'(K_MAX);
      end else begin
         k_eff = CNT_W'(hd_ff);
      end
   end

   // Metadata memory: one read and one write port.
   assign meta_raddr = (state_ff == lkfr_pkg::ST_SCAN) ? idx_ff : IDX_W'(req_data.frame);
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_rd <= meta_mem[meta_raddr];
   end

   // Stamp memory: K_MAX slots per frame.
   always_ff @(posedge clock) begin
      if (stamp_we) begin
         stamp_mem[stamp_waddr] <= clock_ff;
      end
      stamp_rd <= stamp_mem[stamp_raddr];
   end

   lkfr_victim_sel #(
      .FRAME_COUNT (FRAME_COUNT),
      .K_MAX       (K_MAX),
      .STAMP_WIDTH (STAMP_WIDTH)
   ) u_sel (
      .clock      (clock),
      .reset      (reset),
      .clear      (accept),
      .k_eff      (k_eff),
      .meta_valid (s1_valid_ff),
      .meta_idx   (s1_idx_ff),
      .meta_data  (meta_rd),
      .stamp_addr (stamp_raddr),
      .stamp_data (stamp_rd),
      .sel        (sel),
      .victim_idx (victim_idx)
   );

   assign m_head   = meta_rd[HEAD_W-1:0];
   assign m_cnt    = meta_rd[HEAD_W +: CNT_W];
   assign m_ev     = meta_rd[HEAD_W+CNT_W];
   assign m_trk    = meta_rd[HEAD_W+CNT_W+1];
   assign in_range = (7'(req_ff.frame) < fiu_ff) && (32'(req_ff.frame) < FRAME_COUNT);

   // Sequencer: clear pass, request execution and victim scan.
   always_comb begin
      logic [HEAD_W-1:0] base_head;
      logic [CNT_W-1:0]  base_cnt;
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      total_in     = total_ff;
      clock_in     = clock_ff;
      idx_in       = idx_ff;
      issue_in     = issue_ff;
      meta_we      = 1'b0;
      meta_waddr   = IDX_W'(req_ff.frame);
      meta_wdata   = '0;
      stamp_we     = 1'b0;
      base_head    = m_trk ? m_head : '0;
      base_cnt     = m_trk ? m_cnt : '0;
      stamp_waddr  = SA_W'(IDX_W'(req_ff.frame)) * SA_W'(K_MAX) + SA_W'(base_head);
      unique case (state_ff)
         lkfr_pkg::ST_CLR: begin
            meta_we    = 1'b1;
            meta_waddr = idx_ff;
            idx_in     = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(FRAME_COUNT-1)) begin
               idx_in   = '0;
               state_in = lkfr_pkg::ST_IDLE;
            end
         end
         lkfr_pkg::ST_IDLE: begin
            if (accept) begin
               idx_in   = '0;
               issue_in = 1'b1;
               state_in = (req_data.opcode == lkfr_pkg::OpEvict) ?
                          lkfr_pkg::ST_SCAN : lkfr_pkg::ST_EXEC;
            end
         end
         lkfr_pkg::ST_EXEC: begin
            rsp_valid_in        = 1'b1;
            rsp_in.status       = lkfr_pkg::StatusOk;
            rsp_in.victim_frame = '0;
            state_in            = lkfr_pkg::ST_IDLE;
            if (!in_range) begin
               rsp_in.status = lkfr_pkg::StatusInvalid;
            end else begin
               unique case (req_ff.opcode)
                  lkfr_pkg::OpAccess: begin
                     stamp_we = 1'b1;
                     meta_we  = 1'b1;
                     meta_wdata[HEAD_W+CNT_W+1] = 1'b1;
                     meta_wdata[HEAD_W+CNT_W]   = m_trk && m_ev;
                     meta_wdata[HEAD_W +: CNT_W] =
                        (32'(base_cnt) < K_MAX) ? base_cnt + 1'b1 : base_cnt;
                     meta_wdata[HEAD_W-1:0] =
                        (32'(base_head) == K_MAX-1) ? '0 : base_head + 1'b1;
                     clock_in = clock_ff + 1'b1;
                  end
                  lkfr_pkg::OpSetMark: begin
                     if (!m_trk) begin
                        rsp_in.status = lkfr_pkg::StatusInvalid;
                     end else if (m_ev != req_ff.make_evictable) begin
                        meta_we    = 1'b1;
                        meta_wdata = meta_rd;
                        meta_wdata[HEAD_W+CNT_W] = req_ff.make_evictable;
                        if (req_ff.make_evictable) begin
                           total_in = total_ff + 1'b1;
                        end else if (total_ff != '0) begin
                           total_in = total_ff - 1'b1;
                        end
                     end
                  end
                  lkfr_pkg::OpRemove: begin
                     if (m_trk && !m_ev) begin
                        rsp_in.status = lkfr_pkg::StatusPinned;
                     end else if (m_trk) begin
                        meta_we = 1'b1;
                        if (total_ff != '0) begin
                           total_in = total_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                     rsp_in.status = lkfr_pkg::StatusOk;
                  end
               endcase
            end
            rsp_in.evictable_count = 7'(total_in);
         end
         lkfr_pkg::ST_SCAN: begin
            if (issue_ff) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == IDX_W'(FRAME_COUNT-1)) begin
                  idx_in   = '0;
                  issue_in = 1'b0;
               end
            end
            if (sel.done) begin
               state_in = lkfr_pkg::ST_FIN;
            end
         end
         lkfr_pkg::ST_FIN: begin
            rsp_valid_in = 1'b1;
            state_in     = lkfr_pkg::ST_IDLE;
            if (sel.found) begin
               meta_we             = 1'b1;
               meta_waddr          = victim_idx;
               rsp_in.status       = lkfr_pkg::StatusOk;
               rsp_in.victim_frame = 6'(victim_idx);
               if (total_ff != '0) begin
                  total_in = total_ff - 1'b1;
               end
            end else begin
               rsp_in.status       = lkfr_pkg::StatusEmpty;
               rsp_in.victim_frame = '0;
            end
            rsp_in.evictable_count = 7'(total_in);
         end
         default: begin
            state_in = lkfr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkfr_pkg::ST_CLR;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         clock_ff     <= '0;
         idx_ff       <= '0;
         issue_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         clock_ff     <= clock_in;
         idx_ff       <= idx_in;
         issue_ff     <= issue_in;
         s1_valid_ff  <= (state_ff == lkfr_pkg::ST_SCAN) && issue_ff;
      end
      s1_idx_ff <= idx_ff;
      rsp_ff    <= rsp_in;
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // Checks.
   `LKFR_ASSERT_NOW(a_rsp_idle, rsp_valid_ff, state_ff == lkfr_pkg::ST_IDLE, "result outside idle")
   `LKFR_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
   `LKFR_ASSERT_NOW(a_total_bound, 1'b1, 32'(total_ff) <= FRAME_COUNT, "evictable count too large")
   `LKFR_ASSERT_NOW(a_scan_no_write, state_ff == lkfr_pkg::ST_SCAN, !meta_we && !stamp_we, "write during scan")

endmodule
`default_nettype wire
